FILE: rtl/psg_square_tone_generator_core_defines.svh
// assertion helpers used by psg_back
`ifndef PSG_SQUARE_TONE_GENERATOR_CORE_DEFINES_SVH
`define PSG_SQUARE_TONE_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/psg_pkg.sv
`default_nettype none

package psg_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CYCLES_W    = 10;
  localparam int unsigned TONE_W      = 10;
  localparam int unsigned VOL_W       = 4;
  localparam int unsigned GAIN_W      = 8;
  localparam int unsigned SAMPLE_W    = 14;
  localparam int unsigned LATCH_CH_W  = 2;
  localparam int unsigned DATA_W      = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 8'hFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 14'h3FFF;

  // input opcode field
  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_TICK  = 1'b1;

  localparam int unsigned LATCH_BIT = 7;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_LATCH = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e                   op;
    logic [LATCH_CH_W-1:0] chan;
    logic                  is_vol;
    logic [DATA_W-1:0]     data;
    logic [CYCLES_W-1:0]   cycles;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/psg_ifs.sv
`default_nettype none

interface psg_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [psg_pkg::BYTE_W-1:0]   write_byte;
  logic [psg_pkg::CYCLES_W-1:0] tick_cycles;

  modport source (output valid, output opcode, output write_byte, output tick_cycles,
                  input ready);
  modport sink   (input valid, input opcode, input write_byte, input tick_cycles,
                  output ready);
endinterface

interface psg_out_if;
  logic                         valid;
  logic                         ready;
  logic [psg_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface psg_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [psg_pkg::GAIN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/psg_square_tone_generator_core.sv
// channel  dir  handshake      payload
// in_i     in   valid/ready    opcode, write_byte, tick_cycles
// out_o    out  valid/ready    sample_value (one per tick word)
// cfg_i    in   valid/ready    data = master gain, always ready
//
// one word per cycle unless out_o stalls; back end updates all channels at once
// a tick word passes through the queue, the sum register and the sample register
// a two-entry command queue decouples input from the channel update
// an output stall holds the sum and sample registers, the queue then fills
// reset clears all channel state and sets master gain to 8'hFF
`default_nettype none

module psg_square_tone_generator_core #(
  parameter int unsigned CHANNEL_COUNT = 4,
  parameter int unsigned COUNTER_BITS  = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  psg_in_if.sink     in_i,
  psg_out_if.source  out_o,
  psg_cfg_if.sink    cfg_i
);

  logic          push, full, q_valid, pop;
  psg_pkg::cmd_t push_cmd, q_cmd;

  psg_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  psg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (pop)
  );

  psg_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .pop_o       (pop),
    .cfg_i       (cfg_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/psg_front.sv
`default_nettype none

module psg_front (
  psg_in_if.sink          in_i,
  input  wire logic       full_i,
  output logic            push_o,
  output psg_pkg::cmd_t   cmd_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    cmd_o.chan   = in_i.write_byte[6:5];
    cmd_o.is_vol = in_i.write_byte[4];
    cmd_o.data   = in_i.write_byte[psg_pkg::DATA_W-1:0];
    cmd_o.cycles = in_i.tick_cycles;
    unique case (in_i.opcode)
      psg_pkg::OPC_TICK: begin
        cmd_o.op = psg_pkg::OP_TICK;
      end
      default: begin
        // register write word: latch or data byte
        cmd_o.op = in_i.write_byte[psg_pkg::LATCH_BIT] ? psg_pkg::OP_LATCH
                                                        : psg_pkg::OP_DATA;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/psg_queue.sv
`default_nettype none

module psg_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire psg_pkg::cmd_t  cmd_i,
  output logic                full_o,
  output logic                valid_o,
  output psg_pkg::cmd_t       cmd_o,
  input  wire logic           pop_i
);

  localparam int unsigned PTR_W = (psg_pkg::QUEUE_DEPTH > 1) ? $clog2(psg_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(psg_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(psg_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(psg_pkg::QUEUE_DEPTH);

  psg_pkg::cmd_t    mem_q [psg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psg_back.sv
`default_nettype none

`include "psg_square_tone_generator_core_defines.svh"

module psg_back #(
  parameter int unsigned CHANNEL_COUNT = 4,
  parameter int unsigned COUNTER_BITS  = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire psg_pkg::cmd_t  cmd_i,
  output logic                pop_o,
  psg_cfg_if.sink             cfg_i,
  psg_out_if.source           out_o
);

  localparam int unsigned SUM_W  = $clog2(15 * CHANNEL_COUNT + 1);
  localparam int unsigned PROD_W = SUM_W + psg_pkg::GAIN_W;
  localparam int unsigned WIDE_W = (PROD_W > psg_pkg::SAMPLE_W) ? PROD_W : psg_pkg::SAMPLE_W;

  logic [psg_pkg::TONE_W-1:0]  tone_q [CHANNEL_COUNT];
  logic [psg_pkg::VOL_W-1:0]   vol_q  [CHANNEL_COUNT];
  logic [COUNTER_BITS-1:0]     cnt_q  [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0]    lvl_q;
  logic [CHANNEL_COUNT-1:0]    lvl_nx;

  logic [psg_pkg::LATCH_CH_W-1:0] lch_q;
  logic                           lvol_q;
  logic [psg_pkg::GAIN_W-1:0]     gain_q;

  logic [SUM_W-1:0]             sum_d, sum_q;
  logic                         sum_valid_q;
  logic                         out_valid_q;
  logic [psg_pkg::SAMPLE_W-1:0] sample_q;
  logic [WIDE_W-1:0]            prod;
  logic [psg_pkg::SAMPLE_W-1:0] sample_sat;

  logic stall, advance, tick_en, wr_en, wr_low, wr_vol;
  logic [psg_pkg::LATCH_CH_W-1:0] wr_ch;

  assign stall   = out_valid_q && !out_o.ready;
  assign advance = !(sum_valid_q && stall);
  assign pop_o   = cmd_valid_i && advance;
  assign tick_en = pop_o && (cmd_i.op == psg_pkg::OP_TICK);
  assign wr_en   = pop_o && (cmd_i.op == psg_pkg::OP_LATCH || cmd_i.op == psg_pkg::OP_DATA);
  assign wr_low  = (cmd_i.op == psg_pkg::OP_LATCH);
  assign wr_ch   = wr_low ? cmd_i.chan : lch_q;
  assign wr_vol  = wr_low ? cmd_i.is_vol : lvol_q;

  // latch register and gain
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lch_q  <= '0;
      lvol_q <= 1'b0;
      gain_q <= psg_pkg::GAIN_RESET;
    end else begin
      if (pop_o && cmd_i.op == psg_pkg::OP_LATCH) begin
        lch_q  <= cmd_i.chan;
        lvol_q <= cmd_i.is_vol;
      end
      if (cfg_i.valid) begin
        gain_q <= cfg_i.data;
      end
    end
  end

  for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_ch
    logic [COUNTER_BITS:0]   raw;
    logic [COUNTER_BITS-1:0] sat;
    logic [COUNTER_BITS-1:0] per;
    logic                    ge;
    logic                    hit;

    assign raw = {1'b0, cnt_q[i]} + (COUNTER_BITS + 1)'(cmd_i.cycles);
    // counter saturates at all ones
    assign sat = raw[COUNTER_BITS] ? '1 : raw[COUNTER_BITS-1:0];
    assign per = COUNTER_BITS'({({1'b0, tone_q[i]} + 11'd1), 1'b0});
    assign ge  = (sat >= per);
    assign hit = (int'(wr_ch) == i);
    assign lvl_nx[i] = (tone_q[i] == '0) ? 1'b0 : (lvl_q[i] ^ ge);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tone_q[i] <= '0;
        vol_q[i]  <= '0;
        cnt_q[i]  <= '0;
        lvl_q[i]  <= 1'b0;
      end else if (tick_en) begin
        if (tone_q[i] == '0) begin
          cnt_q[i] <= '0;
        end else begin
          cnt_q[i] <= ge ? (sat - per) : sat;
        end
        lvl_q[i] <= lvl_nx[i];
      end else if (wr_en && hit) begin
        if (wr_vol) begin
          vol_q[i] <= cmd_i.data[psg_pkg::VOL_W-1:0];
        end else if (wr_low) begin
          tone_q[i] <= {tone_q[i][9:4], cmd_i.data[3:0]};
        end else begin
          tone_q[i] <= {cmd_i.data[5:0], tone_q[i][3:0]};
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (lvl_nx[i]) begin
        sum_d = sum_d + SUM_W'(vol_q[i]);
      end
    end
  end

  // stage one: volume sum of the channels left high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (advance) begin
      sum_valid_q <= tick_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && tick_en) begin
      sum_q <= sum_d;
    end
  end

  // stage two: gain and clamp into the output register
  assign prod       = WIDE_W'(sum_q) * WIDE_W'(gain_q);
  assign sample_sat = (prod > WIDE_W'(psg_pkg::SAMPLE_MAX)) ? psg_pkg::SAMPLE_MAX
                                                            : prod[psg_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!stall) begin
      out_valid_q <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && sum_valid_q) begin
      sample_q <= sample_sat;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sample_value = sample_q;

  `PSG_ASSERT_NEXT(a_tick_makes_sum, tick_en, sum_valid_q, "tick word produced no sum")
  `PSG_ASSERT_NEXT(a_write_no_sum, wr_en, !sum_valid_q, "register write produced a sum")
  `PSG_ASSERT_NEXT(a_sum_held, sum_valid_q && stall, sum_valid_q && $stable(sum_q),
                   "pending sum lost under stall")
  `PSG_ASSERT_NEXT(a_silent_clears, tick_en && tone_q[0] == '0,
                   !lvl_q[0] && cnt_q[0] == '0, "zero tone left channel running")
  `PSG_ASSERT_NOW(a_pop_needs_room, pop_o, !(sum_valid_q && stall),
                  "word taken while pipeline blocked")

endmodule

`default_nettype wire

FILE: tb/sv/tb_psg_square_tone_generator_core.sv
`default_nettype none

module tb_psg_square_tone_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CH_N  = 4;
  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W:0] CNT_MAX = (17'd1 << CNT_W) - 17'd1;

  localparam logic [psg_pkg::BYTE_W-1:0] LATCH_FLAG = 8'h80;
  localparam logic [psg_pkg::BYTE_W-1:0] VOL_FLAG   = 8'h10;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic clk_i;
  logic rst_ni;

  psg_in_if  in_if ();
  psg_out_if out_if ();
  psg_cfg_if cfg_if ();

  psg_square_tone_generator_core #(
    .CHANNEL_COUNT(CH_N),
    .COUNTER_BITS (CNT_W)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // shadow copy of the generator state
  logic [psg_pkg::TONE_W-1:0]     tone_reg  [CH_N];
  logic [psg_pkg::VOL_W-1:0]      vol_reg   [CH_N];
  logic [CNT_W-1:0]               phase_reg [CH_N];
  logic                           level_reg [CH_N];
  logic [psg_pkg::LATCH_CH_W-1:0] latch_ch;
  logic                           latch_vol;
  logic [psg_pkg::GAIN_W-1:0]     gain_reg;

  logic [psg_pkg::SAMPLE_W-1:0] expected_samples [$];
  int unsigned                  mismatch_count;

  bit src_idle;
  bit sink_idle;
  bit hold_sink;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic tone_model_word(input logic opc, input logic [psg_pkg::BYTE_W-1:0] wb,
                                 input logic [psg_pkg::CYCLES_W-1:0] cyc);
    logic [CNT_W:0]                                acc;
    logic [psg_pkg::TONE_W+1:0]                    period;
    logic [psg_pkg::VOL_W+2:0]                     vsum;
    logic [psg_pkg::VOL_W+2+psg_pkg::GAIN_W:0]     prod;
    int                                            ch;
    if (opc == psg_pkg::OPC_WRITE) begin
      if (wb[psg_pkg::LATCH_BIT]) begin
        latch_ch  = wb[6:5];
        latch_vol = wb[4];
      end
      ch = latch_ch;
      if (ch < CH_N) begin
        if (latch_vol) begin
          vol_reg[ch] = wb[3:0];
        end else if (wb[psg_pkg::LATCH_BIT]) begin
          tone_reg[ch][3:0] = wb[3:0];
        end else begin
          tone_reg[ch][9:4] = wb[5:0];
        end
      end
    end else begin
      vsum = '0;
      for (ch = 0; ch < CH_N; ch++) begin
        if (tone_reg[ch] == '0) begin
          phase_reg[ch] = '0;
          level_reg[ch] = 1'b0;
        end else begin
          acc = {1'b0, phase_reg[ch]} + cyc;
          if (acc > CNT_MAX) acc = CNT_MAX;
          period = ({2'b00, tone_reg[ch]} + 12'd1) << 1;
          // at most one toggle per tick
          if (acc >= period) begin
            acc = acc - period;
            level_reg[ch] = ~level_reg[ch];
          end
          phase_reg[ch] = acc[CNT_W-1:0];
        end
        if (level_reg[ch]) vsum = vsum + vol_reg[ch];
      end
      prod = vsum * gain_reg;
      if (prod > psg_pkg::SAMPLE_MAX) expected_samples.push_back(psg_pkg::SAMPLE_MAX);
      else expected_samples.push_back(prod[psg_pkg::SAMPLE_W-1:0]);
    end
  endtask

  // sample checker
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected sample", out_if.sample_value, -1);
      end else if (out_if.sample_value !== expected_samples[0]) begin
        report_mismatch("sample_value", out_if.sample_value, expected_samples[0]);
        void'(expected_samples.pop_front());
      end else begin
        void'(expected_samples.pop_front());
      end
    end
  end

  // sample receiver with random stalls and one long hold on request
  initial begin : sample_sink
    int n;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        out_if.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        hold_sink = 1'b0;
        out_if.ready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 13);
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic opc, input logic [psg_pkg::BYTE_W-1:0] wb,
                           input logic [psg_pkg::CYCLES_W-1:0] cyc);
    int gap;
    if (src_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= opc;
    in_if.write_byte  <= wb;
    in_if.tick_cycles <= cyc;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tone_model_word(opc, wb, cyc);
  endtask

  task automatic send_write(input logic [psg_pkg::BYTE_W-1:0] wb);
    send_word(psg_pkg::OPC_WRITE, wb, psg_pkg::CYCLES_W'($urandom_range(0, 1023)));
  endtask

  task automatic send_tick(input logic [psg_pkg::CYCLES_W-1:0] cyc);
    send_word(psg_pkg::OPC_TICK, psg_pkg::BYTE_W'($urandom_range(0, 255)), cyc);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    // writes leave no sample behind, so give the pipeline time to settle
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [psg_pkg::GAIN_W-1:0] g);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= g;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    gain_reg = g;
  endtask

  task automatic test_reset_silence();
    send_tick('0);
    send_tick(10'h3FF);
  endtask

  task automatic test_register_protocol();
    send_write(8'h8F);       // ch0 tone low nibble
    send_write(8'h7F);       // data word, bit 6 must be dropped
    send_write(8'h9F);       // ch0 full volume
    send_tick(10'h3FF);
    send_tick(10'h3FF);
    send_tick(10'd2);        // longest period just reached
    send_write(8'hA1);
    send_write(8'h00);       // ch1 tone 1
    send_write(8'hB0);
    send_write(8'h0F);       // data word lands on the latched volume
    send_write(8'hC0);
    send_write(8'h01);       // ch2 tone 16
    send_write(8'hD8);
    send_write(8'hE2);       // ch3 runs as a plain tone
    send_write(8'hF3);
    send_tick(10'h3FF);
    send_tick('0);
    send_tick(10'd1);
    send_write(8'h80);
    send_write(8'h00);       // ch0 tone back to zero clears it
    send_tick(10'd5);
    send_write(8'hFF);
    send_tick(10'h3FF);
    send_tick(10'h2AA);
  endtask

  task automatic test_output_backpressure();
    int i;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_sink = 1'b1;
    for (i = 0; i < 40; i++) send_tick(psg_pkg::CYCLES_W'($urandom_range(0, 1023)));
    wait_drained();
  endtask

  task automatic random_phase(input int n, input bit idle);
    int sent;
    int r;
    int ch;
    logic [psg_pkg::TONE_W-1:0] tone;
    logic [psg_pkg::CYCLES_W-1:0] cyc;
    sent = 0;
    while (sent < n) begin
      if (sent % 64 == 0) begin
        src_idle  = idle && ($urandom_range(0, 3) != 0);
        sink_idle = idle && ($urandom_range(0, 3) != 0);
      end
      r  = $urandom_range(0, 99);
      ch = $urandom_range(0, CH_N - 1);
      if (r < 18) begin
        // latch and data pair, small tones mostly so counters run fast
        r = $urandom_range(0, 9);
        if (r == 0) tone = '0;
        else if (r < 6) tone = psg_pkg::TONE_W'($urandom_range(0, 15));
        else tone = psg_pkg::TONE_W'($urandom_range(0, 1023));
        send_write(LATCH_FLAG | psg_pkg::BYTE_W'(ch << 5) | psg_pkg::BYTE_W'(tone[3:0]));
        send_write({1'b0, 1'($urandom_range(0, 1)), tone[9:4]});
        sent += 2;
      end else if (r < 28) begin
        send_write(LATCH_FLAG | VOL_FLAG | psg_pkg::BYTE_W'(ch << 5) |
                   psg_pkg::BYTE_W'($urandom_range(0, 15)));
        sent++;
      end else if (r < 33) begin
        send_write(psg_pkg::BYTE_W'($urandom_range(0, 127)));
        sent++;
      end else if (r < 38) begin
        send_write(psg_pkg::BYTE_W'($urandom_range(0, 255)));
        sent++;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 2) cyc = '0;
        else if (r < 4) cyc = 10'h3FF;
        else if (r < 7) cyc = psg_pkg::CYCLES_W'($urandom_range(0, 15));
        else cyc = psg_pkg::CYCLES_W'($urandom_range(0, 1023));
        send_tick(cyc);
        sent++;
      end
    end
  endtask

  initial begin : main
    int ch;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.opcode      = psg_pkg::OPC_WRITE;
    in_if.write_byte  = '0;
    in_if.tick_cycles = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    mismatch_count    = 0;
    src_idle          = 1'b1;
    sink_idle         = 1'b1;
    hold_sink         = 1'b0;
    for (ch = 0; ch < CH_N; ch++) begin
      tone_reg[ch]  = '0;
      vol_reg[ch]   = '0;
      phase_reg[ch] = '0;
      level_reg[ch] = 1'b0;
    end
    latch_ch  = '0;
    latch_vol = 1'b0;
    gain_reg  = psg_pkg::GAIN_RESET;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_silence();
    test_register_protocol();
    write_gain(8'd0);
    random_phase(150, 1'b1);
    write_gain(8'd1);
    random_phase(200, 1'b1);
    write_gain(8'd255);
    test_output_backpressure();
    write_gain(psg_pkg::GAIN_W'($urandom_range(0, 255)));
    random_phase(300, 1'b1);
    write_gain(8'd128);
    random_phase(250, 1'b1);
    write_gain(8'd255);
    random_phase(384, 1'b0);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
